/* rtl/core/lprd_pkg.sv */
// Shared types, codes and character constants for the length-prefixed record decoder.
// Used by the front end, the item queue, the back end and the top level.
package lprd_pkg;

  // Width of an accumulated field length; larger lengths are an overflow.
  localparam int unsigned LenWidth  = 16;
  localparam int unsigned PrefixLen = 6;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef enum logic [3:0] {
    PH_PREFIX  = 4'b0001,
    PH_LENGTH  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_COMMA   = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    DS_NONE  = 2'd0,
    DS_ZERO  = 2'd1,
    DS_OTHER = 2'd2
  } digit_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PREFIX    = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  // One classified input item as it travels from the front end to the back end.
  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
    logic       is_zero;
    logic       is_digit;
    logic       is_colon;
    logic       is_comma;
    logic [3:0] digit;
  } item_t;

  // Expected record prefix, one character per position.
  function automatic logic [7:0] prefix_char(logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h4B;
      3'd1:    ch = 8'h4D;
      3'd2:    ch = 8'h4F;
      3'd3:    ch = 8'h44;
      3'd4:    ch = 8'h31;
      3'd5:    ch = 8'h3B;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/core/length_prefixed_record_decoder.sv */
// Top level of the length-prefixed record decoder.
// Instantiates lprd_front, lprd_queue and lprd_back; depends on lprd_pkg.

// The decoder takes one record byte, or the end item, per transfer and
// sustains one transfer per clock when the output side keeps up. A byte goes
// through the two-entry queue and is handled by the back-end state machine
// when the result register is free or draining, and any result it causes
// is then held in the output register. Payload bytes leave as they arrive
// with arg_last on the final byte of each argument, an empty argument gives
// one marker, and the end item gives the record status. Bytes already sent
// are not recalled, so a user must drop the argument bytes of a record whose status is not ok.
module length_prefixed_record_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       arg_last_o,
  output logic [1:0] status_o
);
  import lprd_pkg::*;

  logic  q_full;
  logic  q_push;
  item_t q_item;
  logic  q_pop;
  logic  head_valid;
  item_t head_item;

  // Handshake and classification.
  lprd_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_end_i   (in_end_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_item)
  );

  // Decoupling queue.
  lprd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_item_i  (q_item),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_item_o  (head_item)
  );

  // Parsing and result register.
  lprd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_kind_o   (out_kind_o),
    .out_byte_o   (out_byte_o),
    .arg_last_o   (arg_last_o),
    .status_o     (status_o)
  );

endmodule

/* rtl/core/lprd_front.sv */
// Front end of the record decoder: input handshake and byte classification.
// Depends on lprd_pkg for the item type and character constants.
module lprd_front (
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_byte_i,
  input  logic           in_end_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output lprd_pkg::item_t q_item_o
);
  import lprd_pkg::*;

  // A transfer is taken whenever the queue has room.
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify the byte so that the back end only has to look at flags.
  always_comb begin
    q_item_o.is_end   = in_end_i;
    q_item_o.data     = in_byte_i;
    q_item_o.is_zero  = (in_byte_i == 8'h00);
    q_item_o.is_digit = (in_byte_i >= CharZero) && (in_byte_i <= CharNine);
    q_item_o.is_colon = (in_byte_i == CharColon);
    q_item_o.is_comma = (in_byte_i == CharComma);
    q_item_o.digit    = in_byte_i[3:0];
  end

endmodule

/* rtl/core/lprd_queue.sv */
// Two-entry queue of classified items between the front end and the back end.
// Depends on lprd_pkg for the item type.
module lprd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lprd_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output lprd_pkg::item_t head_item_o
);
  import lprd_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_item_o  = mem_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/core/lprd_back.sv */
// Back end of the record decoder: prefix check, length parsing, payload
// forwarding and the registered result stage. Depends on lprd_pkg.
module lprd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  lprd_pkg::item_t head_item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      out_kind_o,
  output logic [7:0]      out_byte_o,
  output logic            arg_last_o,
  output logic [1:0]      status_o
);
  import lprd_pkg::*;

  phase_e                phase_q, phase_d;
  logic [2:0]            prefix_pos_q, prefix_pos_d;
  logic [LenWidth-1:0]   count_q, count_d;
  digit_e                ds_q, ds_d;
  status_e               pend_q, pend_d;
  status_e               rec_err_q, rec_err_d;

  logic                  emit;
  kind_e                 emit_kind;
  logic [7:0]            emit_byte;
  logic                  emit_last;
  status_e               emit_status;

  logic [LenWidth+3:0]   prod;
  logic                  ovf;

  logic                  out_valid_q;
  kind_e                 out_kind_q;
  logic [7:0]            out_byte_q;
  logic                  arg_last_q;
  status_e               status_q;

  // An item is processed whenever the result register is free or being drained.
  assign pop_o = head_valid_i && (!out_valid_q || out_ready_i);

  // Length accumulation: count * 10 + digit, overflowing past the length width.
  assign prod = {1'b0, count_q, 3'b000} + {3'b000, count_q, 1'b0} +
                {{LenWidth{1'b0}}, head_item_i.digit};
  assign ovf  = |prod[LenWidth+3:LenWidth];

  // Record state machine, one item per transfer.
  always_comb begin
    phase_d      = phase_q;
    prefix_pos_d = prefix_pos_q;
    count_d      = count_q;
    ds_d         = ds_q;
    pend_d       = pend_q;
    rec_err_d    = rec_err_q;
    emit         = 1'b0;
    emit_kind    = KIND_BYTE;
    emit_byte    = 8'h00;
    emit_last    = 1'b0;
    emit_status  = ST_OK;

    if (pop_o) begin
      priority if (head_item_i.is_end) begin
        // End of record: report status and return to the reset state.
        emit        = 1'b1;
        emit_kind   = KIND_STATUS;
        emit_status = rec_err_q;
        if (rec_err_q == ST_OK) begin
          if (phase_q == PH_PREFIX) begin
            emit_status = ST_PREFIX;
          end else if (phase_q == PH_LENGTH) begin
            emit_status = (ds_q == DS_NONE && pend_q == ST_OK) ? ST_OK : ST_MALFORMED;
          end else begin
            emit_status = ST_MALFORMED;
          end
        end
        phase_d      = PH_PREFIX;
        prefix_pos_d = 3'd0;
        count_d      = '0;
        ds_d         = DS_NONE;
        pend_d       = ST_OK;
        rec_err_d    = ST_OK;
      end else if (rec_err_q != ST_OK) begin
        // The first error stands; bytes are ignored until the end item.
        emit = 1'b0;
      end else if (phase_q == PH_PREFIX) begin
        if (head_item_i.data != prefix_char(prefix_pos_q)) begin
          rec_err_d = ST_PREFIX;
        end else begin
          prefix_pos_d = prefix_pos_q + 3'd1;
          if (prefix_pos_q == 3'(PrefixLen - 1)) begin
            phase_d = PH_LENGTH;
            count_d = '0;
            ds_d    = DS_NONE;
            pend_d  = ST_OK;
          end
        end
      end else if (head_item_i.is_zero) begin
        rec_err_d = ST_MALFORMED;
      end else begin
        unique case (phase_q)
          PH_LENGTH: begin
            if (head_item_i.is_colon) begin
              // The colon settles any fault found in the length.
              if (ds_q == DS_NONE) begin
                rec_err_d = ST_MALFORMED;
              end else if (pend_q != ST_OK) begin
                rec_err_d = pend_q;
              end else if (count_q == '0) begin
                phase_d   = PH_COMMA;
                emit      = 1'b1;
                emit_kind = KIND_EMPTY;
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end else if (ds_q == DS_ZERO || !head_item_i.is_digit) begin
              // Leading zero followed by anything, or a non-digit.
              if (pend_q == ST_OK) begin
                pend_d = ST_MALFORMED;
              end
              ds_d = DS_OTHER;
            end else if (ds_q == DS_NONE && head_item_i.digit == 4'd0) begin
              ds_d    = DS_ZERO;
              count_d = '0;
            end else begin
              ds_d = DS_OTHER;
              if (pend_q == ST_OK) begin
                if (ovf) begin
                  pend_d = ST_OVERFLOW;
                end else begin
                  count_d = prod[LenWidth-1:0];
                end
              end
            end
          end
          PH_PAYLOAD: begin
            // Forward the byte and mark the last one of the argument.
            count_d   = count_q - {{(LenWidth-1){1'b0}}, 1'b1};
            emit      = 1'b1;
            emit_kind = KIND_BYTE;
            emit_byte = head_item_i.data;
            if (count_q == {{(LenWidth-1){1'b0}}, 1'b1}) begin
              emit_last = 1'b1;
              phase_d   = PH_COMMA;
            end
          end
          PH_COMMA: begin
            if (head_item_i.is_comma) begin
              phase_d = PH_LENGTH;
              count_d = '0;
              ds_d    = DS_NONE;
              pend_d  = ST_OK;
            end else begin
              rec_err_d = ST_MALFORMED;
            end
          end
          default: begin
            rec_err_d = ST_MALFORMED;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_PREFIX;
      prefix_pos_q <= 3'd0;
      count_q      <= '0;
      ds_q         <= DS_NONE;
      pend_q       <= ST_OK;
      rec_err_q    <= ST_OK;
    end else begin
      phase_q      <= phase_d;
      prefix_pos_q <= prefix_pos_d;
      count_q      <= count_d;
      ds_q         <= ds_d;
      pend_q       <= pend_d;
      rec_err_q    <= rec_err_d;
    end
  end

  // Result register: filled on an emitted result, emptied by a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q <= emit_kind;
      out_byte_q <= emit_byte;
      arg_last_q <= emit_last;
      status_q   <= emit_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign arg_last_o  = arg_last_q;
  assign status_o    = status_q;

endmodule
